// ===== hdl/fcd_pkg.sv =====
// Shared constants and register indexes for the feedback comb delay unit.
`timescale 1ns / 1ps

package fcd_pkg;

	localparam int MAX_DELAY_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int LEN_W     = 13;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 15;
	localparam int LEN_RESET = 4096;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_DELAY_LENGTH  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_FEEDBACK_GAIN = cfg_idx_t'(1);

endpackage

// ===== hdl/feedback_comb_delay_unit.sv =====
// Top level of the feedback comb delay unit: delay RAM, index control and output queue.
`timescale 1ns / 1ps

// The unit takes one sample beat per clock while in_stall is low and returns one sample
// beat per input beat, in order, through the registered RAM read and the output queue.
// The rate of one beat per cycle is set by the delay RAM, which gives one write and one
// read each cycle: the entry under the write index is updated while the entry under the
// next index is read, and that read value is both the result and the entry the next
// sample updates. A two-entry output queue absorbs stalls on the output side. After reset
// the unit clears the delay RAM one entry per cycle, all MAX_DELAY entries, and holds
// in_stall high meanwhile; configuration writes are taken during that time.
module feedback_comb_delay_unit #(
	parameter int MAX_DELAY   = fcd_pkg::MAX_DELAY_DEF,
	parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  fcd_pkg::cfg_idx_t                   cfg_index,
	input  logic [fcd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample_out
);

	localparam int IDX_W = $clog2(MAX_DELAY);
	localparam int CW    = (fcd_pkg::LEN_W > IDX_W + 1) ? fcd_pkg::LEN_W : IDX_W + 1;

	logic                              clr_q;
	logic [IDX_W-1:0]                  clr_idx_q;
	logic [fcd_pkg::LEN_W-1:0]         len_q;
	logic signed [fcd_pkg::GAIN_W-1:0] gain_q;
	logic [IDX_W-1:0]                  wr_idx_q;
	logic signed [SAMPLE_BITS-1:0]     cur_q;
	logic                              valid_s1;
	logic                              fwd_s1;
	logic signed [SAMPLE_BITS-1:0]     fwd_data_s1;
	logic signed [SAMPLE_BITS-1:0]     fifo_q [2];
	logic                              fifo_wr_q;
	logic                              fifo_rd_q;
	logic [1:0]                        fifo_cnt_q;

	logic                              accept;
	logic                              pop;
	logic [CW-1:0]                     len_ext;
	logic [CW-1:0]                     eff_len;
	logic [IDX_W:0]                    idx_inc;
	logic [IDX_W-1:0]                  idx_next;
	logic signed [SAMPLE_BITS-1:0]     cur;
	logic signed [SAMPLE_BITS-1:0]     new_val;
	logic [SAMPLE_BITS-1:0]            ram_rdata;
	logic                              ram_we;
	logic [IDX_W-1:0]                  ram_waddr;
	logic [SAMPLE_BITS-1:0]            ram_wdata;
	logic [2:0]                        occ;

	assign len_ext = CW'(len_q);

	always_comb begin
		priority if (len_ext == '0) begin
			eff_len = CW'(1);
		end else if (len_ext > CW'(MAX_DELAY)) begin
			eff_len = CW'(MAX_DELAY);
		end else begin
			eff_len = len_ext;
		end
	end

	assign idx_inc  = {1'b0, wr_idx_q} + (IDX_W+1)'(1);
	assign idx_next = (CW'(idx_inc) >= eff_len) ? '0 : idx_inc[IDX_W-1:0];

	assign cur = valid_s1 ? (fwd_s1 ? fwd_data_s1 : $signed(ram_rdata)) : cur_q;

	fcd_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.entry (cur),
		.gain  (gain_q),
		.sample(sample_in),
		.result(new_val)
	);

	assign accept    = in_valid && !in_stall;
	assign ram_we    = clr_q || accept;
	assign ram_waddr = clr_q ? clr_idx_q : wr_idx_q;
	assign ram_wdata = clr_q ? '0 : new_val;

	fcd_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_DELAY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(idx_next),
		.rdata(ram_rdata)
	);

	assign out_valid  = (fifo_cnt_q != 2'd0);
	assign sample_out = fifo_q[fifo_rd_q];
	assign pop        = out_valid && !out_stall;
	assign occ        = {1'b0, fifo_cnt_q} + {2'b00, valid_s1} - {2'b00, pop};
	assign in_stall   = clr_q || (occ > 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == IDX_W'(MAX_DELAY - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= fcd_pkg::LEN_W'(fcd_pkg::LEN_RESET);
			gain_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fcd_pkg::REG_DELAY_LENGTH: begin
					len_q <= cfg_data[fcd_pkg::LEN_W-1:0];
				end
				fcd_pkg::REG_FEEDBACK_GAIN: begin
					gain_q <= $signed(cfg_data[fcd_pkg::GAIN_W-1:0]);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			cur_q    <= '0;
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			cur_q    <= cur;
			valid_s1 <= accept;
			if (accept) begin
				wr_idx_q <= idx_next;
				fwd_s1   <= (idx_next == wr_idx_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_data_s1 <= new_val;
		end
		if (valid_s1) begin
			fifo_q[fifo_wr_q] <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_wr_q  <= 1'b0;
			fifo_rd_q  <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (valid_s1) begin
				fifo_wr_q <= !fifo_wr_q;
			end
			if (pop) begin
				fifo_rd_q <= !fifo_rd_q;
			end
			fifo_cnt_q <= fifo_cnt_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_queue_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && (fifo_cnt_q == 2'd2) && !pop))
		else $error("Output queue overflow.");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (!valid_s1 && (fifo_cnt_q == 2'd0)))
		else $error("Sample in flight during RAM clearing.");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ({1'b0, wr_idx_q} < (IDX_W+1)'(MAX_DELAY)))
		else $error("Write index beyond delay RAM.");
`endif

endmodule

// ===== hdl/fcd_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module fcd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/fcd_mac.sv =====
// Feedback arithmetic: entry times gain, rounded, plus input, saturated.
`timescale 1ns / 1ps

module fcd_mac #(
	parameter int SAMPLE_BITS = fcd_pkg::SAMPLE_BITS_DEF
) (
	input  logic signed [SAMPLE_BITS-1:0]      entry,
	input  logic signed [fcd_pkg::GAIN_W-1:0]  gain,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	output logic signed [SAMPLE_BITS-1:0]      result
);

	localparam int PW = SAMPLE_BITS + fcd_pkg::GAIN_W;
	localparam int SW = PW + 1 - fcd_pkg::GAIN_FRAC;
	localparam logic signed [SW-1:0] MAXV = SW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [SW-1:0] MINV = ~MAXV;

	logic signed [PW-1:0] prod;
	logic signed [PW:0]   rnd;
	logic signed [SW-1:0] shf;
	logic signed [SW-1:0] sx;
	logic signed [SW-1:0] sum;

	assign prod = entry * gain;
	assign rnd  = {prod[PW-1], prod} + (PW+1)'(64'd1 << (fcd_pkg::GAIN_FRAC - 1));
	assign shf  = rnd[PW:fcd_pkg::GAIN_FRAC];
	assign sx   = sample;
	assign sum  = shf + sx;

	always_comb begin
		priority if (sum > MAXV) begin
			result = MAXV[SAMPLE_BITS-1:0];
		end else if (sum < MINV) begin
			result = MINV[SAMPLE_BITS-1:0];
		end else begin
			result = sum[SAMPLE_BITS-1:0];
		end
	end

endmodule
